[design/assert_macros.svh]
// Assertion macros for the checker file of the match raster.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("match raster check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DMR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("match raster check failed");

`endif

[design/dmr_pkg.sv]
// Shared types and constants for the dot plot match raster.
// No dependencies; used by the top level and by its checker.
package dmr_pkg;

	// Default edge length of the square grid.
	localparam int GRID_SIZE_DEF = 256;

	// Item kinds carried on the kind port.
	localparam logic [1:0] KIND_PLOT = 2'd0;
	localparam logic [1:0] KIND_EOQ  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	// Configuration register indexes (word address bit 2).
	localparam logic REG_SPAN = 1'b0;
	localparam logic REG_MASK = 1'b1;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROW_CHK,
		ST_ROW_DIV,
		ST_COL_CHK,
		ST_COL_DIV,
		ST_ADDR,
		ST_WALK_RD,
		ST_WALK_WR,
		ST_CELL_RD,
		ST_RESULT
	} dmr_state_t;

endpackage

[design/dotplot_match_raster.sv]
// Top level of the dot plot match raster: sequencer, shared compare/subtract unit and cell store.
// Depends on dmr_pkg.
//
// Usage. An item is transferred at a rising edge where start is high and busy is low.
// kind selects plot match, end of query or read cell; a read gives one result, shown on
// cell_value and max_seen for exactly one cycle while result_valid is high. The receiver
// cannot stall, so every result must be taken in that cycle.
// After reset the block sweeps the cell store to zero, one entry per cycle, holding busy
// high until all GRID_SIZE*GRID_SIZE entries are cleared. Configuration writes
// over the APB port are taken at any time, but are meant to be made while the block is idle.
// Sequence. End-of-query items, unused kinds and plot items whose diagonal is masked are
// taken without raising busy.
// A read passes through a store read state and then the result state, both with busy high.
// A plot item checks and divides for the row bin, then for the column bin, forms the cell
// address, then reads and writes each cell along the diagonal until the match length is
// covered or the walk runs into the grid edge. A row or column bin off the grid ends the item.
// Row and column bins are found by one restoring division
// each, a bit per cycle, on the shared compare/subtract unit, and each cell along the
// diagonal needs a read step and a write step on the store.
module dotplot_match_raster
	import dmr_pkg::*;
#(
	parameter int GRID_SIZE = GRID_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Item channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [31:0] ref_pos,
	input  logic [31:0] query_pos,
	input  logic [31:0] match_len,
	input  logic [31:0] query_size,
	input  logic [7:0]  cell_row,
	input  logic [7:0]  cell_col,
	// Result channel
	output logic        result_valid,
	output logic [31:0] cell_value,
	output logic [31:0] max_seen
);

	localparam int GW    = $clog2(GRID_SIZE);
	localparam int RW    = GW + 1;
	localparam int AW    = $clog2(GRID_SIZE * GRID_SIZE);
	localparam int NW    = 35 + GW;
	localparam int CW    = $clog2(GW);
	localparam int DEPTH = GRID_SIZE * GRID_SIZE;

	localparam logic [RW-1:0] G_R       = RW'(GRID_SIZE);
	localparam logic [AW-1:0] CLR_LAST  = AW'(DEPTH - 1);
	localparam logic [AW-1:0] DIAG_STEP = AW'(GRID_SIZE + 1);
	localparam logic [CW-1:0] CNT_LAST  = CW'(GW - 1);

	dmr_state_t state_q, state_d;

	// Control and architectural registers
	logic [31:0]   span_q;
	logic          mask_q;
	logic [31:0]   offset_q;
	logic [31:0]   max_q;
	logic [AW-1:0] clr_q;

	// Datapath registers
	logic [NW-1:0] num_q;
	logic [NW-1:0] gd_q;
	logic [32:0]   d_q;
	logic [32:0]   rem_q;
	logic [GW-1:0] lo_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] row_q;
	logic [RW-1:0] col_q;
	logic [AW-1:0] addr_q;
	logic [NW-1:0] acc_q;
	logic [NW-1:0] leng_q;
	logic [31:0]   len_q;
	logic [32:0]   posc_q;
	logic [31:0]   span_e_q;
	logic          rd_ok_q;
	logic [31:0]   rdata_q;

	// Shared compare/subtract unit
	logic [NW-1:0] unit_a, unit_b, unit_diff;
	logic          unit_ge;

	logic [33:0]   div_t;
	logic [31:0]   span_eff;
	logic [32:0]   eoq_sum;
	logic          accept;
	logic          cfg_wr;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic [31:0]   mem [DEPTH];

	assign accept    = start && (state_q == ST_IDLE);
	assign span_eff  = (span_q == '0) ? 32'd1 : span_q;
	assign eoq_sum   = {1'b0, offset_q} + {1'b0, query_size};
	assign div_t     = {rem_q, lo_q[GW-1]};
	assign unit_diff = unit_a - unit_b;
	assign unit_ge   = (unit_a >= unit_b);

	// Configuration port: writes complete in the access phase, reads are combinational.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_MASK) ? {31'd0, mask_q} : span_q;

	// Status and result outputs.
	assign busy         = (state_q != ST_IDLE);
	assign result_valid = (state_q == ST_RESULT);
	assign cell_value   = rd_ok_q ? rdata_q : 32'd0;
	assign max_seen     = max_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and operand selection for the shared unit.
	always_comb begin
		state_d = state_q;
		unit_a  = '0;
		unit_b  = '0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					case (kind)
						KIND_PLOT: begin
							if (!(mask_q && (ref_pos == query_pos))) state_d = ST_ROW_CHK;
						end
						KIND_READ: state_d = ST_CELL_RD;
						default: ;
					endcase
				end
			end
			ST_ROW_CHK, ST_COL_CHK: begin
				// A numerator of at least GRID_SIZE divisors puts the bin off the grid.
				unit_a = num_q;
				unit_b = gd_q;
				if (unit_ge) state_d = ST_IDLE;
				else if (state_q == ST_ROW_CHK) state_d = ST_ROW_DIV;
				else state_d = ST_COL_DIV;
			end
			ST_ROW_DIV, ST_COL_DIV: begin
				unit_a = NW'(div_t);
				unit_b = NW'(d_q);
				if (cnt_q == '0) begin
					state_d = (state_q == ST_ROW_DIV) ? ST_COL_CHK : ST_ADDR;
				end
			end
			ST_ADDR: state_d = ST_WALK_RD;
			ST_WALK_RD: begin
				if ((row_q >= G_R) || (col_q >= G_R)) state_d = ST_IDLE;
				else state_d = ST_WALK_WR;
			end
			ST_WALK_WR: begin
				// Stop once (k+1)*span reaches len*GRID_SIZE.
				unit_a = acc_q;
				unit_b = leng_q;
				state_d = unit_ge ? ST_IDLE : ST_WALK_RD;
			end
			ST_CELL_RD: state_d = ST_RESULT;
			ST_RESULT:  state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Control registers: configuration, column offset, running maximum, clear pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q   <= 32'd1;
			mask_q   <= 1'b0;
			offset_q <= '0;
			max_q    <= '0;
			clr_q    <= '0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_SPAN) span_q <= pwdata;
				else mask_q <= pwdata[0];
			end
			if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (accept && (kind == KIND_EOQ)) begin
				offset_q <= eoq_sum[32] ? 32'hFFFF_FFFF : eoq_sum[31:0];
			end
			if ((state_q == ST_WALK_WR) && (len_q > max_q)) max_q <= len_q;
		end
	end

	// Datapath registers for binning, division and the diagonal walk.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					num_q    <= ((NW'(ref_pos) * NW'(GRID_SIZE)) << 1) + NW'(span_eff);
					gd_q     <= NW'({span_eff, 1'b0}) * NW'(GRID_SIZE);
					d_q      <= {span_eff, 1'b0};
					span_e_q <= span_eff;
					len_q    <= match_len;
					leng_q   <= NW'(match_len) * NW'(GRID_SIZE);
					posc_q   <= {1'b0, query_pos} + {1'b0, offset_q};
					rd_ok_q  <= (32'(cell_row) < 32'(GRID_SIZE)) &&
						(32'(cell_col) < 32'(GRID_SIZE));
					addr_q   <= AW'(AW'(cell_row) * AW'(GRID_SIZE)) + AW'(cell_col);
				end
			end
			ST_ROW_CHK, ST_COL_CHK: begin
				rem_q <= num_q[GW +: 33];
				lo_q  <= num_q[GW-1:0];
				cnt_q <= CNT_LAST;
			end
			ST_ROW_DIV, ST_COL_DIV: begin
				// One restoring division step: quotient bits shift in below the dividend bits.
				rem_q <= unit_ge ? unit_diff[32:0] : div_t[32:0];
				lo_q  <= {lo_q[GW-2:0], unit_ge};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					if (state_q == ST_ROW_DIV) begin
						row_q <= {1'b0, lo_q[GW-2:0], unit_ge};
						num_q <= ((NW'(posc_q) * NW'(GRID_SIZE)) << 1) + NW'(span_e_q);
					end else begin
						col_q <= {1'b0, lo_q[GW-2:0], unit_ge};
					end
				end
			end
			ST_ADDR: begin
				addr_q <= AW'(AW'(row_q) * AW'(GRID_SIZE)) + AW'(col_q);
				acc_q  <= NW'(span_e_q);
			end
			ST_WALK_WR: begin
				if (!unit_ge) begin
					row_q  <= row_q + RW'(1);
					col_q  <= col_q + RW'(1);
					addr_q <= addr_q + DIAG_STEP;
					acc_q  <= acc_q + NW'(span_e_q);
				end
			end
			default: ;
		endcase
	end

	// Store write port: zero sweep after reset, then max updates during the walk.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = len_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_WALK_WR: mem_we = (len_q > rdata_q);
			default: ;
		endcase
	end

	// Cell store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[addr_q];
	end

endmodule

[design/dmr_checker.sv]
// Port-level checker for the dot plot match raster, with its bind to the top level.
// Depends on dmr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dmr_checker
	import dmr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [1:0] kind,
	input logic       result_valid
);

	// A result is only shown while the block is still occupied with the read.
	`DMR_ASSERT_IMP(a_result_busy, result_valid, busy)
	// Each result transfer lasts a single cycle.
	`DMR_ASSERT_NXT(a_result_single, result_valid, !result_valid)
	// An accepted read keeps the block busy and does not answer at once.
	`DMR_ASSERT_NXT(a_read_waits, start && !busy && (kind == KIND_READ), busy && !result_valid)
	// A result is preceded by a busy cycle spent reading the store.
	`DMR_ASSERT_IMP(a_result_after_read, result_valid, $past(busy))
	// End of query completes in the cycle it is transferred.
	`DMR_ASSERT_NXT(a_eoq_quick, start && !busy && (kind == KIND_EOQ), !busy)

endmodule

bind dotplot_match_raster dmr_checker u_dmr_checker (.*);
